// ===== rtl/tlbpt_pkg.sv =====
// Shared constants for the TLB and page-table translator.
`default_nettype none

package tlbpt_pkg;

    localparam int ADDR_W          = 16;
    localparam int COUNT_W         = 16;
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 8;
    localparam int OFFSET_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

endpackage

`default_nettype wire

// ===== rtl/tlbpt_in_if.sv =====
// Address request channel: one logical address per beat.
`default_nettype none

interface tlbpt_in_if;

    logic                          valid;
    logic                          ready;
    logic [tlbpt_pkg::ADDR_W-1:0]  logical_address;

    modport source (output valid, output logical_address, input ready);
    modport sink   (input valid, input logical_address, output ready);

endinterface

`default_nettype wire

// ===== rtl/tlbpt_out_if.sv =====
// Translation result channel: physical address, flags and running totals per beat.
`default_nettype none

interface tlbpt_out_if;

    logic                          valid;
    logic                          ready;
    logic [tlbpt_pkg::ADDR_W-1:0]  physical_address;
    logic                          tlb_hit;
    logic                          page_fault;
    logic [tlbpt_pkg::COUNT_W-1:0] hit_count;
    logic [tlbpt_pkg::COUNT_W-1:0] fault_count;

    modport source (output valid, output physical_address, output tlb_hit,
                    output page_fault, output hit_count, output fault_count,
                    input ready);
    modport sink   (input valid, input physical_address, input tlb_hit,
                    input page_fault, input hit_count, input fault_count,
                    output ready);

endinterface

`default_nettype wire

// ===== rtl/tlbpt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tlbpt_front.sv =====
// Front end: accepts addresses, searches the TLB and refills it after a miss.
`default_nettype none

module tlbpt_front #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_BITS   = tlbpt_pkg::PAGE_BITS_DEF,
    parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF,
    localparam int QW         = 2 * PAGE_BITS + OFFSET_BITS + 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tlbpt_in_if.sink                  request,
    output      logic                 q_push_valid,
    input  wire logic                 q_push_ready,
    output      logic [QW-1:0]        q_push_data,
    input  wire logic                 fill_valid,
    input  wire logic [PAGE_BITS-1:0] fill_frame
);

    localparam int PTR_W = $clog2(TLB_ENTRIES);

    logic [PAGE_BITS-1:0]   tag_reg   [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]   frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [PTR_W-1:0]       ptr_reg;
    logic [PTR_W-1:0]       ptr_next;
    logic                   wait_fill_reg;
    logic                   wait_fill_next;
    logic [PAGE_BITS-1:0]   miss_page_reg;

    logic [PAGE_BITS-1:0]   page;
    logic [OFFSET_BITS-1:0] offset;
    logic                   hit;
    logic [PAGE_BITS-1:0]   hit_frame;
    logic                   accept;

    assign page   = PAGE_BITS'(request.logical_address >> OFFSET_BITS);
    assign offset = OFFSET_BITS'(request.logical_address);

    // lowest matching slot wins
    always_comb
    begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == page))
            begin
                hit       = 1'b1;
                hit_frame = frame_reg[i];
            end
        end
    end

    assign request.ready = !wait_fill_reg && q_push_ready;
    assign accept        = request.valid && request.ready;
    assign q_push_valid  = request.valid && !wait_fill_reg;
    assign q_push_data   = {page, offset, hit_frame, hit};

    assign ptr_next = (ptr_reg == PTR_W'(TLB_ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        wait_fill_next = wait_fill_reg;
        if (accept && !hit)
        begin
            wait_fill_next = 1'b1;
        end
        else if (fill_valid)
        begin
            wait_fill_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ptr_reg       <= '0;
            wait_fill_reg <= 1'b0;
        end
        else
        begin
            wait_fill_reg <= wait_fill_next;
            if (fill_valid)
            begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !hit)
        begin
            miss_page_reg <= page;
        end
        if (fill_valid)
        begin
            tag_reg[ptr_reg]   <= miss_page_reg;
            frame_reg[ptr_reg] <= fill_frame;
        end
    end

    a_fill_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        fill_valid |-> wait_fill_reg)
        else $error("TLB refill without an outstanding miss");

    a_miss_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !hit) |=> !request.ready)
        else $error("new address taken before TLB refill");

endmodule

`default_nettype wire

// ===== rtl/tlbpt_queue.sv =====
// Short FIFO between the front end and the page-table back end.
`default_nettype none

module tlbpt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tlbpt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      logic [WIDTH-1:0] pop_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg;
    logic [IW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy out of range");

endmodule

`default_nettype wire

// ===== rtl/tlbpt_back.sv =====
// Back end: page-table walk, frame allocation, totals and the result register.
`default_nettype none

module tlbpt_back #(
    parameter int PAGE_BITS   = tlbpt_pkg::PAGE_BITS_DEF,
    parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF,
    localparam int QW         = 2 * PAGE_BITS + OFFSET_BITS + 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_pop_valid,
    output      logic                 q_pop_ready,
    input  wire logic [QW-1:0]        q_pop_data,
    output      logic                 fill_valid,
    output      logic [PAGE_BITS-1:0] fill_frame,
    tlbpt_out_if.source               result
);

    localparam int AW        = tlbpt_pkg::ADDR_W;
    localparam int CNTW      = tlbpt_pkg::COUNT_W;
    localparam int NUM_PAGES = 1 << PAGE_BITS;
    localparam int PTE_W     = PAGE_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } back_state_t;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [PAGE_BITS-1:0]   clr_reg;
    logic [PAGE_BITS-1:0]   clr_next;
    logic [PAGE_BITS:0]     frames_reg;
    logic [PAGE_BITS:0]     frames_next;
    logic [CNTW-1:0]        hit_total_reg;
    logic [CNTW-1:0]        hit_total_next;
    logic [CNTW-1:0]        fault_total_reg;
    logic [CNTW-1:0]        fault_total_next;
    logic [PAGE_BITS-1:0]   page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [AW-1:0]          phys_reg;
    logic                   hit_reg;
    logic                   fault_reg;

    logic [PAGE_BITS-1:0]   q_page;
    logic [OFFSET_BITS-1:0] q_offset;
    logic [PAGE_BITS-1:0]   q_frame;
    logic                   q_hit;

    logic                   ram_we;
    logic [PAGE_BITS-1:0]   ram_waddr;
    logic [PTE_W-1:0]       ram_wdata;
    logic [PAGE_BITS-1:0]   ram_raddr;
    logic [PTE_W-1:0]       ram_rdata;

    logic                   out_free;
    logic                   emit;
    logic [PAGE_BITS-1:0]   emit_frame;
    logic [OFFSET_BITS-1:0] emit_offset;
    logic                   emit_hit;
    logic                   emit_fault;
    logic                   pte_mapped;
    logic [PAGE_BITS-1:0]   miss_frame;

    assign q_page   = q_pop_data[QW-1 -: PAGE_BITS];
    assign q_offset = q_pop_data[QW-PAGE_BITS-1 -: OFFSET_BITS];
    assign q_frame  = q_pop_data[PAGE_BITS:1];
    assign q_hit    = q_pop_data[0];

    // page-table entry: mapped flag above the frame number
    tlbpt_ram #(
        .WIDTH (PTE_W),
        .DEPTH (NUM_PAGES)
    ) u_page_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr  = (state_reg == ST_READ) ? page_reg : q_page;
    assign pte_mapped = ram_rdata[PAGE_BITS];
    assign miss_frame = pte_mapped ? ram_rdata[PAGE_BITS-1:0] : frames_reg[PAGE_BITS-1:0];
    assign out_free   = !out_valid_reg || result.ready;
    assign fill_frame = miss_frame;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        frames_next      = frames_reg;
        hit_total_next   = hit_total_reg;
        fault_total_next = fault_total_reg;
        q_pop_ready      = 1'b0;
        fill_valid       = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = page_reg;
        ram_wdata        = {1'b1, miss_frame};
        emit             = 1'b0;
        emit_frame       = q_frame;
        emit_offset      = q_offset;
        emit_hit         = 1'b1;
        emit_fault       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_pop_valid)
                begin
                    if (q_hit)
                    begin
                        if (out_free)
                        begin
                            q_pop_ready    = 1'b1;
                            emit           = 1'b1;
                            hit_total_next = (hit_total_reg == '1) ? hit_total_reg
                                                                   : hit_total_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop_ready = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_frame  = miss_frame;
                    emit_offset = offset_reg;
                    emit_hit    = 1'b0;
                    emit_fault  = !pte_mapped;
                    fill_valid  = 1'b1;
                    state_next  = ST_IDLE;
                    if (!pte_mapped)
                    begin
                        ram_we           = 1'b1;
                        fault_total_next = (fault_total_reg == '1) ? fault_total_reg
                                                                   : fault_total_reg + 1'b1;
                        if (!frames_reg[PAGE_BITS])
                        begin
                            frames_next = frames_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            frames_reg      <= '0;
            hit_total_reg   <= '0;
            fault_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            frames_reg      <= frames_next;
            hit_total_reg   <= hit_total_next;
            fault_total_reg <= fault_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop_ready && !q_hit)
        begin
            page_reg   <= q_page;
            offset_reg <= q_offset;
        end
        if (emit)
        begin
            phys_reg  <= AW'({emit_frame, emit_offset});
            hit_reg   <= emit_hit;
            fault_reg <= emit_fault;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.physical_address = phys_reg;
    assign result.tlb_hit          = hit_reg;
    assign result.page_fault       = fault_reg;
    assign result.hit_count        = hit_total_reg;
    assign result.fault_count      = fault_total_reg;

    a_faults_match_frames: assert property (@(posedge clk) disable iff (!rst_n)
        fault_total_reg == CNTW'(frames_reg))
        else $error("fault total and frame allocator disagree");

    a_fill_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        fill_valid |=> (result.valid && !result.tlb_hit))
        else $error("TLB refill without a miss result");

endmodule

`default_nettype wire

// ===== rtl/tlb_page_table_translator.sv =====
// Top level of the TLB and page-table address translator.
// Each beat on request carries a 16-bit logical address; the page field is looked up in a
// fully associative TLB of TLB_ENTRIES slots and, on a miss, in a page table of
// 2^PAGE_BITS entries held in RAM. An unmapped page is given the next free frame (frames are
// never released), and every miss refills the TLB slot under a FIFO pointer. Each result beat
// gives the physical address, hit and fault flags and saturating 16-bit hit and fault totals.
// A TLB hit is answered in ST_IDLE, so hits stream at one beat per cycle while results are
// taken; a miss goes through ST_READ for the registered page-table RAM read and the TLB
// refill, during which no new address is taken. After reset the page table is swept clear,
// one entry a cycle, all 2^PAGE_BITS entries (256 by default); the TLB starts empty, so only
// the first address is taken during the sweep and no result appears until it ends.
`default_nettype none

module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_BITS   = tlbpt_pkg::PAGE_BITS_DEF,
    parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = tlbpt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlbpt_in_if.sink    request,
    tlbpt_out_if.source result
);

    localparam int QW = 2 * PAGE_BITS + OFFSET_BITS + 1;

    logic                 push_valid;
    logic                 push_ready;
    logic [QW-1:0]        push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [QW-1:0]        pop_data;
    logic                 fill_valid;
    logic [PAGE_BITS-1:0] fill_frame;

    tlbpt_front #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_BITS   (PAGE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .q_push_valid (push_valid),
        .q_push_ready (push_ready),
        .q_push_data  (push_data),
        .fill_valid   (fill_valid),
        .fill_frame   (fill_frame)
    );

    tlbpt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tlbpt_back #(
        .PAGE_BITS   (PAGE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_pop_valid (pop_valid),
        .q_pop_ready (pop_ready),
        .q_pop_data  (pop_data),
        .fill_valid  (fill_valid),
        .fill_frame  (fill_frame),
        .result      (result)
    );

endmodule

`default_nettype wire
